FILE: rtl/srls_pkg.sv
// Shared types and constants for the staggered relay load switch.
// Used by srls_step and staggered_relay_load_switch_unit; no dependencies.
package srls_pkg;

    localparam int RELAY_COUNT = 8;
    localparam int LANE_COUNT  = 8;
    localparam int PRICE_W     = 16;
    localparam int TICK_W      = 16;
    localparam int INDEX_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [TICK_W-1:0]  TICK_MAX       = 16'hFFFF;
    localparam logic [INDEX_W-1:0] NO_RELAY       = 4'd8;
    localparam logic [15:0]        ON_THR_RESET   = 16'd1000;
    localparam logic [15:0]        OFF_THR_RESET  = 16'd1200;
    localparam logic [TICK_W-1:0]  STAGGER_RESET  = 16'd10;

    // Item operations
    localparam logic OP_PRICE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAGGER     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 3'd6;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BELOW = 2'd2,
        MODE_AUTO  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [LANE_COUNT-1:0][1:0]         modes;
        logic [LANE_COUNT-1:0][PRICE_W-1:0] on_thr;
        logic [LANE_COUNT-1:0][PRICE_W-1:0] off_thr;
        logic [TICK_W-1:0]                  stagger;
        logic                               active_low;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        relay_on;
        logic [7:0]        pending;
        logic [TICK_W-1:0] ticks;
        logic              any_on;
    } state_t;

    typedef struct packed {
        logic [7:0]         pin_levels;
        logic [7:0]         relays_on;
        logic [7:0]         pending_mask;
        logic               pins_written;
        logic [INDEX_W-1:0] turned_on_index;
    } result_t;

endpackage

FILE: rtl/staggered_relay_load_switch_unit.sv
// Top level of the staggered relay load switch: configuration registers,
// relay state registers and the result register. Depends on srls_pkg, srls_step.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one item: opcode (0 price update,
//    1 time tick), price and price_valid. Each item yields exactly one result.
//  - Output channel (out_valid/out_ready) carries pin_levels, relays_on,
//    pending_mask, pins_written and turned_on_index.
//  - The result of an item is registered and is valid after the edge that
//    accepts it. Throughput is one item per cycle while the receiver takes
//    each result; the relay state is updated in the same cycle by the single
//    step unit, so the next item sees it at once.
//  - in_ready is high whenever the result register is empty or being taken
//    in the same cycle; a stalled receiver holds the result and stops input
//    after one item.
//  - The configuration port (cfg_write_en, cfg_index, cfg_data) writes one
//    register per cycle; write only while idle. Unknown indexes are ignored.
//  - Reset clears all relays, pending bits, the tick counter and the turn-on
//    flag, and loads the default thresholds, stagger window and polarity.
module staggered_relay_load_switch_unit
    import srls_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [PRICE_W-1:0]     price,
    input  logic                   price_valid,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             pin_levels,
    output logic [7:0]             relays_on,
    output logic [7:0]             pending_mask,
    output logic                   pins_written,
    output logic [INDEX_W-1:0]     turned_on_index
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modes      <= '0;
            cfg_reg.on_thr     <= {LANE_COUNT{ON_THR_RESET}};
            cfg_reg.off_thr    <= {LANE_COUNT{OFF_THR_RESET}};
            cfg_reg.stagger    <= STAGGER_RESET;
            cfg_reg.active_low <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MODES:      cfg_reg.modes       <= cfg_data[15:0];
                REG_ON_THR_LO:  cfg_reg.on_thr[3:0]  <= cfg_data;
                REG_ON_THR_HI:  cfg_reg.on_thr[7:4]  <= cfg_data;
                REG_OFF_THR_LO: cfg_reg.off_thr[3:0] <= cfg_data;
                REG_OFF_THR_HI: cfg_reg.off_thr[7:4] <= cfg_data;
                REG_STAGGER:    cfg_reg.stagger     <= cfg_data[TICK_W-1:0];
                REG_ACTIVE_LOW: cfg_reg.active_low  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    srls_step u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .opcode      (opcode),
        .price       (price),
        .price_valid (price_valid),
        .state_next  (state_next),
        .result      (result_next)
    );

    // Advance relay state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign pin_levels      = result_reg.pin_levels;
    assign relays_on       = result_reg.relays_on;
    assign pending_mask    = result_reg.pending_mask;
    assign pins_written    = result_reg.pins_written;
    assign turned_on_index = result_reg.turned_on_index;

endmodule

FILE: rtl/srls_step.sv
// Combinational step logic: price evaluation, tick count and dispatch.
// Depends on srls_pkg for the state, configuration and result types.
module srls_step
    import srls_pkg::*;
(
    input  cfg_t                cfg,
    input  state_t              state,
    input  logic                opcode,
    input  logic [PRICE_W-1:0]  price,
    input  logic                price_valid,
    output state_t              state_next,
    output result_t             result
);

    logic [7:0]         on_eval;
    logic [7:0]         pend_eval;
    logic [TICK_W-1:0]  ticks_eval;
    logic               changed;
    logic               want;
    logic               found;
    logic [2:0]         pick;
    logic               allowed;
    logic [7:0]         on_final;
    logic [7:0]         pend_final;
    mode_t              mode;

    // Evaluate the price per relay, or advance the tick counter
    always_comb
    begin
        on_eval    = state.relay_on;
        pend_eval  = state.pending;
        ticks_eval = state.ticks;
        changed    = 1'b0;
        want       = 1'b0;
        mode       = MODE_OFF;
        if (opcode == OP_PRICE)
        begin
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                mode = mode_t'(cfg.modes[i]);
                want = state.relay_on[i];
                case (mode)
                    MODE_OFF:   want = 1'b0;
                    MODE_ON:    want = 1'b1;
                    MODE_BELOW:
                    begin
                        if (price_valid)
                            want = (price <= cfg.on_thr[i]);
                    end
                    MODE_AUTO:
                    begin
                        if (price_valid)
                        begin
                            if (price <= cfg.on_thr[i])
                                want = 1'b1;
                            else if (price >= cfg.off_thr[i])
                                want = 1'b0;
                        end
                    end
                    default:    want = state.relay_on[i];
                endcase
                if (want == state.relay_on[i])
                begin
                    if (!want)
                        pend_eval[i] = 1'b0;
                end
                else if (want)
                begin
                    pend_eval[i] = 1'b1;
                end
                else
                begin
                    on_eval[i]   = 1'b0;
                    pend_eval[i] = 1'b0;
                    changed      = 1'b1;
                end
            end
        end
        else if (state.ticks < TICK_MAX)
        begin
            ticks_eval = state.ticks + 1'b1;
        end
    end

    // Pick the lowest pending relay
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = RELAY_COUNT - 1; i >= 0; i--)
        begin
            if (pend_eval[i])
            begin
                found = 1'b1;
                pick  = 3'(i);
            end
        end
    end

    assign allowed = found && ((cfg.stagger == '0) || !state.any_on ||
                               (ticks_eval >= cfg.stagger));

    // Dispatch one turn-on and build the result
    always_comb
    begin
        on_final   = on_eval;
        pend_final = pend_eval;
        state_next.ticks  = ticks_eval;
        state_next.any_on = state.any_on;
        result.turned_on_index = NO_RELAY;
        if (allowed)
        begin
            on_final[pick]   = 1'b1;
            pend_final[pick] = 1'b0;
            state_next.ticks  = '0;
            state_next.any_on = 1'b1;
            result.turned_on_index = {1'b0, pick};
        end
        state_next.relay_on = on_final;
        state_next.pending  = pend_final;

        result.relays_on    = on_final;
        result.pending_mask = pend_final;
        result.pins_written = changed || allowed;
        for (int i = 0; i < 8; i++)
        begin
            if (i < RELAY_COUNT)
                result.pin_levels[i] = cfg.active_low ? ~on_final[i] : on_final[i];
            else
                result.pin_levels[i] = 1'b1;
        end
    end

endmodule
